### src/nnu_pkg.sv
`default_nettype none
package nnu_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_FACTOR_DEF = 8;

  localparam int PIX_W        = 32;
  localparam int WIDTH_REG_W  = 7;
  localparam int HEIGHT_REG_W = 13;
  localparam int FACTOR_REG_W = 4;
  localparam int ROW_W        = 12;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int OUT_USER_W   = 3;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int CMD_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_REPLAY = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]        pixel;
    logic                    from_store;
    logic [FACTOR_REG_W-1:0] count;
    logic                    row_end;
    logic                    frame_end;
    logic                    rejected;
  } cmd_t;

endpackage
`default_nettype wire

### src/nearest_neighbor_pixel_upscaler_unit.sv
// channel | direction | payload
// cfg     | in        | cfg_index: register 0 width, 1 height, 2 factor; cfg_data: value
// s_axis  | in        | s_tdata: source pixel; s_tuser: mode (0 pixel, 1 replay tick)
// m_axis  | out       | m_tdata: pixel; m_tlast: last of run; m_tuser: row/frame end, rejected
//
// One output beat per cycle while commands are queued and m_tready is high; an item gives
// factor beats at the output (one for a rejected pixel), counted by the beat counter of the output stage.
// Input side takes up to one item per cycle while the four-entry command queue has room.
// Synchronous reset: registers 24/24/4, counters cleared, no line store clearing pass.
// Stalls on m_tready hold the output register; the input side stalls only when the queue fills.
`default_nettype none
module nearest_neighbor_pixel_upscaler_unit #(
  parameter int MAX_WIDTH  = nnu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = nnu_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [nnu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nnu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [nnu_pkg::PIX_W-1:0]       s_tdata,   // [31:0] pixel_in
  input  wire logic                            s_tuser,   // [0] mode
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [nnu_pkg::PIX_W-1:0]            m_tdata,   // [31:0] pixel_out
  output logic                                 m_tlast,
  output logic [nnu_pkg::OUT_USER_W-1:0]       m_tuser    // [0] row_end [1] frame_end [2] rejected
);

  logic                             cmd_push;
  nnu_pkg::cmd_t                    cmd_data;
  nnu_pkg::cmd_t                    head;
  logic                             head_valid;
  logic                             pop;
  logic [nnu_pkg::CMD_CNT_W-1:0]    fifo_count;

  assign cfg_ready = 1'b1;

  nnu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_mode    (s_tuser),
    .s_pixel   (s_tdata),
    .fifo_count(fifo_count),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data)
  );

  nnu_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_data),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .count     (fifo_count)
  );

  nnu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

### src/nnu_ram.sv
`default_nettype none
module nnu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/nnu_front.sv
`default_nettype none
module nnu_front #(
  parameter int MAX_WIDTH  = nnu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = nnu_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [nnu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nnu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic                           s_mode,
  input  wire logic [nnu_pkg::PIX_W-1:0]      s_pixel,
  input  wire logic [nnu_pkg::CMD_CNT_W-1:0]  fifo_count,
  output logic                                cmd_push,
  output nnu_pkg::cmd_t                       cmd_data
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = $clog2(MAX_FACTOR);
  localparam int CMPW = 14;
  localparam int FCW  = 8;

  logic [nnu_pkg::WIDTH_REG_W-1:0]  src_width;
  logic [nnu_pkg::HEIGHT_REG_W-1:0] src_height;
  logic [nnu_pkg::FACTOR_REG_W-1:0] scale_factor;

  logic [CW-1:0]             write_column;
  logic [CW-1:0]             read_column;
  logic [RW-1:0]             replay_row;
  logic [nnu_pkg::ROW_W-1:0] source_row;
  logic                      replaying;

  logic          s1_valid;
  nnu_pkg::cmd_t s1_cmd;

  logic [nnu_pkg::WIDTH_REG_W-1:0]  eff_w;
  logic [nnu_pkg::HEIGHT_REG_W-1:0] eff_h;
  logic [nnu_pkg::FACTOR_REG_W-1:0] eff_f;
  logic                             wr_row_end;
  logic                             rd_row_end;
  logic                             last_row;
  logic                             last_pass;
  logic [nnu_pkg::ROW_W-1:0]        source_row_next;
  logic                             accept;
  logic                             is_pixel;
  logic [nnu_pkg::PIX_W-1:0]        store_rdata;

  always_comb begin
    if (src_width == '0) begin
      eff_w = nnu_pkg::WIDTH_REG_W'(1);
    end else if (CMPW'(src_width) > CMPW'(MAX_WIDTH)) begin
      eff_w = nnu_pkg::WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      eff_w = src_width;
    end
    if (src_height == '0) begin
      eff_h = nnu_pkg::HEIGHT_REG_W'(1);
    end else if (CMPW'(src_height) > CMPW'(nnu_pkg::MAX_HEIGHT)) begin
      eff_h = nnu_pkg::HEIGHT_REG_W'(nnu_pkg::MAX_HEIGHT);
    end else begin
      eff_h = src_height;
    end
    if (scale_factor == '0) begin
      eff_f = nnu_pkg::FACTOR_REG_W'(1);
    end else if (FCW'(scale_factor) > FCW'(MAX_FACTOR)) begin
      eff_f = nnu_pkg::FACTOR_REG_W'(MAX_FACTOR);
    end else begin
      eff_f = scale_factor;
    end
  end

  assign wr_row_end = (CMPW'(write_column) + CMPW'(1)) >= CMPW'(eff_w);
  assign rd_row_end = (CMPW'(read_column) + CMPW'(1)) >= CMPW'(eff_w);
  assign last_row   = (CMPW'(source_row) + CMPW'(1)) >= CMPW'(eff_h);
  assign last_pass  = (FCW'(replay_row) + FCW'(2)) >= FCW'(eff_f);
  assign source_row_next = last_row ? '0 : source_row + nnu_pkg::ROW_W'(1);

  assign s_tready = ((nnu_pkg::CMD_CNT_W + 1)'(fifo_count) + (nnu_pkg::CMD_CNT_W + 1)'(s1_valid))
                    < (nnu_pkg::CMD_CNT_W + 1)'(nnu_pkg::CMD_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign is_pixel = (s_mode == nnu_pkg::MODE_PIXEL);

  nnu_ram #(
    .WIDTH(nnu_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (accept && is_pixel && !replaying),
    .waddr(write_column),
    .wdata(s_pixel),
    .raddr(read_column),
    .rdata(store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= nnu_pkg::WIDTH_REG_W'(24);
      src_height   <= nnu_pkg::HEIGHT_REG_W'(24);
      scale_factor <= nnu_pkg::FACTOR_REG_W'(4);
      write_column <= '0;
      read_column  <= '0;
      replay_row   <= '0;
      source_row   <= '0;
      replaying    <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          nnu_pkg::REG_SRC_WIDTH:    src_width    <= cfg_data[nnu_pkg::WIDTH_REG_W-1:0];
          nnu_pkg::REG_SRC_HEIGHT:   src_height   <= cfg_data[nnu_pkg::HEIGHT_REG_W-1:0];
          nnu_pkg::REG_SCALE_FACTOR: scale_factor <= cfg_data[nnu_pkg::FACTOR_REG_W-1:0];
          default: ;
        endcase
      end
      s1_valid <= accept && (is_pixel || replaying);
      if (accept) begin
        priority if (is_pixel && !replaying) begin
          if (wr_row_end) begin
            write_column <= '0;
            if (eff_f > nnu_pkg::FACTOR_REG_W'(1)) begin
              replaying   <= 1'b1;
              replay_row  <= '0;
              read_column <= '0;
            end else begin
              source_row <= source_row_next;
            end
          end else begin
            write_column <= write_column + CW'(1);
          end
        end else if (!is_pixel && replaying) begin
          if (rd_row_end) begin
            read_column <= '0;
            if (last_pass) begin
              replaying  <= 1'b0;
              replay_row <= '0;
              source_row <= source_row_next;
            end else begin
              replay_row <= replay_row + RW'(1);
            end
          end else begin
            read_column <= read_column + CW'(1);
          end
        end else begin
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      priority if (is_pixel && replaying) begin
        s1_cmd.pixel      <= '0;
        s1_cmd.from_store <= 1'b0;
        s1_cmd.count      <= nnu_pkg::FACTOR_REG_W'(1);
        s1_cmd.row_end    <= 1'b0;
        s1_cmd.frame_end  <= 1'b0;
        s1_cmd.rejected   <= 1'b1;
      end else if (is_pixel) begin
        s1_cmd.pixel      <= s_pixel;
        s1_cmd.from_store <= 1'b0;
        s1_cmd.count      <= eff_f;
        s1_cmd.row_end    <= wr_row_end;
        s1_cmd.frame_end  <= wr_row_end && (eff_f == nnu_pkg::FACTOR_REG_W'(1)) && last_row;
        s1_cmd.rejected   <= 1'b0;
      end else begin
        s1_cmd.pixel      <= '0;
        s1_cmd.from_store <= 1'b1;
        s1_cmd.count      <= eff_f;
        s1_cmd.row_end    <= rd_row_end;
        s1_cmd.frame_end  <= rd_row_end && last_pass && last_row;
        s1_cmd.rejected   <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd_push = s1_valid;
    cmd_data = s1_cmd;
    if (s1_cmd.from_store) begin
      cmd_data.pixel = store_rdata;
    end
  end

endmodule
`default_nettype wire

### src/nnu_cmd_fifo.sv
`default_nettype none
module nnu_cmd_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire nnu_pkg::cmd_t                 push_data,
  input  wire logic                          pop,
  output nnu_pkg::cmd_t                      head,
  output logic                               head_valid,
  output logic [nnu_pkg::CMD_CNT_W-1:0]      count
);

  nnu_pkg::cmd_t                   entries [nnu_pkg::CMD_DEPTH];
  logic [nnu_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [nnu_pkg::CMD_PTR_W-1:0]   rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + nnu_pkg::CMD_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + nnu_pkg::CMD_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + nnu_pkg::CMD_CNT_W'(1);
        2'b01:   count <= count - nnu_pkg::CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/nnu_back.sv
`default_nettype none
module nnu_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire nnu_pkg::cmd_t                   head,
  input  wire logic                            head_valid,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [nnu_pkg::PIX_W-1:0]            m_tdata,
  output logic                                 m_tlast,
  output logic [nnu_pkg::OUT_USER_W-1:0]       m_tuser
);

  logic [nnu_pkg::FACTOR_REG_W-1:0] beat;
  logic                             load;
  logic                             last;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign last = (beat + nnu_pkg::FACTOR_REG_W'(1)) == head.count;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      beat     <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      beat     <= last ? '0 : beat + nnu_pkg::FACTOR_REG_W'(1);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= head.pixel;
      m_tlast <= last;
      m_tuser <= {head.rejected, last && head.frame_end, last && head.row_end};
    end
  end

endmodule
`default_nettype wire
